// ===== hdl/bcg_pkg.sv =====
package bcg_pkg;

    // Field and datapath widths
    localparam int DIM_W  = 13;  // size and weight width
    localparam int PIX_W  = 12;  // coordinate width
    localparam int CH_W   = 8;   // one color channel
    localparam int COL_W  = 24;  // packed corner color
    localparam int SUM_W  = 21;  // one row blend: weight * channel, two terms
    localparam int DEN_W  = 26;  // (W-1)*(H-1)
    localparam int NUM_W  = 34;  // full bilinear numerator
    localparam int NCH    = 3;   // red, green, blue

    // Pipeline layout: weights, row blend, column blend, then one quotient bit per stage
    localparam int FRONT_STG = 3;
    localparam int DIV_STG   = CH_W;
    localparam int NSTG      = FRONT_STG + DIV_STG;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH        = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COLOR_TOP_LEFT     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_COLOR_TOP_RIGHT    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COLOR_BOTTOM_LEFT  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_COLOR_BOTTOM_RIGHT = 3'd5;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [CH_W-1:0]  quo_t;

endpackage

// ===== hdl/bcg_div_step.sv =====
module bcg_div_step
(
    input  logic              clk,
    input  logic              en,
    input  bcg_pkg::num_t     rem_in,
    input  bcg_pkg::quo_t     quo_in,
    input  bcg_pkg::num_t     dvs,      // divisor already shifted to this bit position
    output bcg_pkg::num_t     rem_reg,
    output bcg_pkg::quo_t     quo_reg
);
    import bcg_pkg::*;

    num_t rem_next;
    quo_t quo_next;
    logic ge;

    // One restoring step: trial subtract, keep on no borrow
    always_comb
    begin
        ge       = (rem_in >= dvs);
        rem_next = ge ? (rem_in - dvs) : rem_in;
        quo_next = {quo_in[CH_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// ===== hdl/bilinear_corner_gradient_pixel.sv =====
// Pipeline: an accepted pixel passes 3 interpolation stages, then an 8-stage restoring
// divider (one quotient bit each), before its color appears on m_tdata.
// Throughput: one pixel per cycle unless the output stalls; each stage advances when it is
// empty or its successor advances, so a stalled output only holds the stages behind it.
// Reset: rst_n clears all stage valid bits and loads the configuration defaults.
module bilinear_corner_gradient_pixel
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int CHANNEL_MAX   = 255
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [bcg_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [bcg_pkg::COL_W-1:0]     cfg_wdata,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // color output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import bcg_pkg::*;

    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIMENSION > 8191) ? 13'd8191 : DIM_W'(MAX_DIMENSION);
    localparam logic [CH_W-1:0]  CH_RST  = CH_W'(CHANNEL_MAX);

    // Configuration registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] tl_reg;
    logic [COL_W-1:0] tr_reg;
    logic [COL_W-1:0] bl_reg;
    logic [COL_W-1:0] br_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd256;
            height_reg <= 13'd256;
            tl_reg     <= {16'd0, CH_RST};
            tr_reg     <= {CH_RST, CH_RST, CH_RST};
            bl_reg     <= '0;
            br_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:        width_reg  <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:       height_reg <= cfg_wdata[DIM_W-1:0];
                REG_COLOR_TOP_LEFT:     tl_reg     <= cfg_wdata;
                REG_COLOR_TOP_RIGHT:    tr_reg     <= cfg_wdata;
                REG_COLOR_BOTTOM_LEFT:  bl_reg     <= cfg_wdata;
                REG_COLOR_BOTTOM_RIGHT: br_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamped sizes, minus one
    logic [DIM_W-1:0] wm1;
    logic [DIM_W-1:0] hm1;

    always_comb
    begin
        wm1 = ((width_reg < 13'd2) ? 13'd2 : ((width_reg > DIM_CAP) ? DIM_CAP : width_reg))
              - 13'd1;
        hm1 = ((height_reg < 13'd2) ? 13'd2 : ((height_reg > DIM_CAP) ? DIM_CAP : height_reg))
              - 13'd1;
    end

    // Divisor, refreshed every cycle from the quiet configuration
    logic [DEN_W-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        den_reg <= DEN_W'(wm1) * DEN_W'(hm1);
    end

    // Stage valid bits and the advance chain
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTG-1];

    // Stage 1: saturate coordinates, form the four weights
    logic [DIM_W-1:0] xs;
    logic [DIM_W-1:0] ys;
    logic [DIM_W-1:0] wl_reg, wr_reg, wt_reg, wb_reg;

    always_comb
    begin
        xs = {1'b0, s_tdata[PIX_W-1:0]};
        ys = {1'b0, s_tdata[2*PIX_W-1:PIX_W]};
        if (xs > wm1)
        begin
            xs = wm1;
        end
        if (ys > hm1)
        begin
            ys = hm1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            wl_reg <= wm1 - xs;
            wr_reg <= xs;
            wt_reg <= hm1 - ys;
            wb_reg <= ys;
        end
    end

    // Stage 2: blend along each row, per channel
    logic [SUM_W-1:0] top_reg [NCH];
    logic [SUM_W-1:0] bot_reg [NCH];
    logic [DIM_W-1:0] wt2_reg, wb2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int c = 0; c < NCH; c++)
            begin
                top_reg[c] <= SUM_W'(wl_reg) * SUM_W'(tl_reg[COL_W-1-CH_W*c -: CH_W])
                            + SUM_W'(wr_reg) * SUM_W'(tr_reg[COL_W-1-CH_W*c -: CH_W]);
                bot_reg[c] <= SUM_W'(wl_reg) * SUM_W'(bl_reg[COL_W-1-CH_W*c -: CH_W])
                            + SUM_W'(wr_reg) * SUM_W'(br_reg[COL_W-1-CH_W*c -: CH_W]);
            end
            wt2_reg <= wt_reg;
            wb2_reg <= wb_reg;
        end
    end

    // Stage 3: blend the two rows into the numerator
    num_t num_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int c = 0; c < NCH; c++)
            begin
                num_reg[c] <= NUM_W'(wt2_reg) * NUM_W'(top_reg[c])
                            + NUM_W'(wb2_reg) * NUM_W'(bot_reg[c]);
            end
        end
    end

    // Stages 4..11: restoring division, most significant quotient bit first
    num_t rem_s [DIV_STG+1][NCH];
    quo_t quo_s [DIV_STG+1][NCH];
    num_t dvs_s [DIV_STG];

    for (genvar c = 0; c < NCH; c++)
    begin : g_seed
        assign rem_s[0][c] = num_reg[c];
        assign quo_s[0][c] = '0;
    end

    for (genvar j = 0; j < DIV_STG; j++)
    begin : g_div
        assign dvs_s[j] = NUM_W'(den_reg) << (DIV_STG - 1 - j);
        for (genvar c = 0; c < NCH; c++)
        begin : g_ch
            bcg_div_step u_step
            (
                .clk     (clk),
                .en      (en[FRONT_STG + j]),
                .rem_in  (rem_s[j][c]),
                .quo_in  (quo_s[j][c]),
                .dvs     (dvs_s[j]),
                .rem_reg (rem_s[j+1][c]),
                .quo_reg (quo_s[j+1][c])
            );
        end
    end

    assign m_tdata = {quo_s[DIV_STG][2], quo_s[DIV_STG][1], quo_s[DIV_STG][0]};

    // Checks
    logic in_xact;
    logic out_xact;
    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = m_tvalid && m_tready;

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(v_reg) == $past($countones(v_reg))
                  + int'($past(in_xact)) - int'($past(out_xact))))
        else $error("pipeline occupancy does not match transactions");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NSTG-1] |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[FRONT_STG-1] |-> (den_reg != '0))
        else $error("zero divisor reached the divider");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTG-1] && !m_tready) |=> (v_reg[NSTG-1] && $stable(m_tdata)))
        else $error("held result changed before it was taken");

endmodule
